FILE: rtl/core/lcdns_pkg.sv
package lcdns_pkg;

	// Request opcodes
	typedef enum logic [1:0] {
		OP_CHAR   = 2'd0,
		OP_CURSOR = 2'd1,
		OP_INIT   = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	// Configuration register indexes
	localparam logic CFG_DISPLAY_TYPE = 1'b0;
	localparam logic CFG_LINE_LENGTH  = 1'b1;

	localparam logic [1:0] DISPLAY_TYPE_RST = 2'd2;
	localparam logic [6:0] LINE_LENGTH_RST  = 7'd20;

	// Special characters
	localparam logic [7:0] CH_FORM_FEED = 8'h0C;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_BACKSPACE = 8'h08;

	// Commands
	localparam logic [7:0] CMD_CLEAR      = 8'h01;
	localparam logic [7:0] CMD_ROW2_HOME  = 8'hC0;
	localparam logic [7:0] CMD_SHIFT_LEFT = 8'h10;
	localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
	localparam logic [7:0] CMD_FUNC_SET   = 8'h20;
	localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
	localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
	localparam logic [7:0] ROW1_BASE      = 8'h80;
	localparam logic [7:0] ROW2_BASE      = 8'hC0;

	// Waits in microseconds
	localparam logic [12:0] DATA_WAIT_US    = 13'd200;
	localparam logic [12:0] CMD_WAIT_US     = 13'd2000;
	localparam logic [12:0] CLEAR_WAIT_US   = 13'd4000;
	localparam logic [12:0] WAKE_WAIT_US    = 13'd6000;
	localparam logic [14:0] POWERUP_WAIT_US = 15'd25000;

	localparam logic [3:0] WAKE_NIBBLE  = 4'h3;
	localparam logic [3:0] FOUR_BIT_NIB = 4'h2;

	localparam logic [3:0] STEP_BYTE_LAST = 4'd1;
	localparam logic [3:0] STEP_INIT_LAST = 4'd11;

	localparam int FIFO_DEPTH_DEF = 2;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] char_code;
		logic [6:0] column;
		logic [2:0] row;
	} in_t;

	typedef struct packed {
		logic        register_select;
		logic [3:0]  nibble;
		logic [14:0] wait_before_us;
		logic [12:0] wait_after_us;
		logic        last;
	} out_t;

	// Classified request handed from front to back
	typedef struct packed {
		logic        is_init;
		logic        rs;
		logic [7:0]  value;    // byte to send, or function set byte for init
		logic [12:0] wait_lo;  // wait after the low nibble of a byte
	} desc_t;

	function automatic logic [3:0] last_step(input desc_t d);
		return d.is_init ? STEP_INIT_LAST : STEP_BYTE_LAST;
	endfunction

	// One nibble write for a given step of a request
	function automatic out_t step_result(input desc_t d, input logic [3:0] step);
		out_t r;
		r.register_select = d.rs;
		r.nibble          = 4'h0;
		r.wait_before_us  = '0;
		r.wait_after_us   = '0;
		r.last            = (step == last_step(d));
		if (!d.is_init) begin
			r.nibble        = step[0] ? d.value[3:0] : d.value[7:4];
			r.wait_after_us = step[0] ? d.wait_lo : '0;
		end else begin
			r.register_select = 1'b0;
			case (step)
				4'd0: begin
					r.nibble         = WAKE_NIBBLE;
					r.wait_before_us = POWERUP_WAIT_US;
					r.wait_after_us  = WAKE_WAIT_US;
				end
				4'd1, 4'd2: begin
					r.nibble        = WAKE_NIBBLE;
					r.wait_after_us = WAKE_WAIT_US;
				end
				4'd3:  r.nibble = FOUR_BIT_NIB;
				4'd4:  r.nibble = d.value[7:4];
				4'd5:  r.nibble = d.value[3:0];
				4'd6:  r.nibble = CMD_DISP_ON[7:4];
				4'd7:  r.nibble = CMD_DISP_ON[3:0];
				4'd8:  r.nibble = CMD_CLEAR[7:4];
				4'd9:  r.nibble = CMD_CLEAR[3:0];
				4'd10: r.nibble = CMD_ENTRY_MODE[7:4];
				4'd11: r.nibble = CMD_ENTRY_MODE[3:0];
				default: r.nibble = 4'h0;
			endcase
			if (step >= 4'd5 && step[0])
				r.wait_after_us = CMD_WAIT_US;
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/lcdns_front.sv
module lcdns_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_addr,
	input  logic [6:0]           cfg_wdata,
	input  logic                 take,
	input  lcdns_pkg::in_t       req,
	output logic                 push,
	output lcdns_pkg::desc_t     desc
);

	logic [1:0] display_type_q;
	logic [6:0] line_length_q;
	logic [7:0] base;
	logic [7:0] addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_type_q <= lcdns_pkg::DISPLAY_TYPE_RST;
			line_length_q  <= lcdns_pkg::LINE_LENGTH_RST;
		end else if (cfg_we) begin
			if (cfg_addr == lcdns_pkg::CFG_DISPLAY_TYPE)
				display_type_q <= cfg_wdata[1:0];
			else
				line_length_q <= cfg_wdata;
		end
	end

	// Row base address; out-of-range rows fall back to row one
	always_comb begin
		case (req.row)
			3'd2:    base = lcdns_pkg::ROW2_BASE;
			3'd3:    base = lcdns_pkg::ROW1_BASE + {1'b0, line_length_q};
			3'd4:    base = lcdns_pkg::ROW2_BASE + {1'b0, line_length_q};
			default: base = lcdns_pkg::ROW1_BASE;
		endcase
	end

	assign addr = base + {1'b0, req.column} - 8'd1;

	always_comb begin
		desc.is_init = 1'b0;
		desc.rs      = 1'b0;
		desc.value   = '0;
		desc.wait_lo = lcdns_pkg::CMD_WAIT_US;
		push         = take;
		case (lcdns_pkg::opcode_t'(req.opcode))
			lcdns_pkg::OP_CHAR: begin
				case (req.char_code)
					lcdns_pkg::CH_FORM_FEED: begin
						desc.value   = lcdns_pkg::CMD_CLEAR;
						desc.wait_lo = lcdns_pkg::CLEAR_WAIT_US;
					end
					lcdns_pkg::CH_NEWLINE:   desc.value = lcdns_pkg::CMD_ROW2_HOME;
					lcdns_pkg::CH_BACKSPACE: desc.value = lcdns_pkg::CMD_SHIFT_LEFT;
					default: begin
						desc.rs      = 1'b1;
						desc.value   = req.char_code;
						desc.wait_lo = lcdns_pkg::DATA_WAIT_US;
					end
				endcase
			end
			lcdns_pkg::OP_CURSOR: desc.value = lcdns_pkg::CMD_SET_DDRAM | addr;
			lcdns_pkg::OP_INIT: begin
				desc.is_init = 1'b1;
				desc.value   = lcdns_pkg::CMD_FUNC_SET | {4'b0, display_type_q, 2'b0};
			end
			default: push = 1'b0;  // unused opcode: taken and dropped
		endcase
	end

endmodule

FILE: rtl/core/lcdns_fifo.sv
module lcdns_fifo #(
	parameter int DEPTH = lcdns_pkg::FIFO_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  lcdns_pkg::desc_t     wdata,
	input  logic                 pop,
	output lcdns_pkg::desc_t     rdata,
	output logic                 full,
	output logic                 empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	lcdns_pkg::desc_t mem_q [DEPTH];
	logic [PtrW-1:0]  wptr_q;
	logic [PtrW-1:0]  rptr_q;
	logic [CntW-1:0]  count_q;

	assign full  = (count_q == CntW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop)
				rptr_q <= (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != CntW'(DEPTH)))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue read while empty");

endmodule

FILE: rtl/core/lcdns_back.sv
module lcdns_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  lcdns_pkg::desc_t     q_desc,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lcdns_pkg::out_t      out_data
);

	lcdns_pkg::desc_t cur_q;
	logic             cur_valid_q;
	logic [3:0]       step_q;
	logic             out_valid_q;
	lcdns_pkg::out_t  out_q;
	logic             advance;
	logic             at_end;

	assign advance = cur_valid_q && (!out_valid_q || out_ready);
	assign at_end  = (step_q == lcdns_pkg::last_step(cur_q));
	assign q_pop   = q_valid && (!cur_valid_q || (advance && at_end));

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_desc;
		if (advance)
			out_q <= lcdns_pkg::step_result(cur_q, step_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				step_q      <= '0;
			end else if (advance) begin
				if (at_end)
					cur_valid_q <= 1'b0;
				step_q <= step_q + 1'b1;
			end
		end
	end

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (step_q <= lcdns_pkg::last_step(cur_q)))
		else $error("step counter ran past end of request");

	a_powerup_only_first: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.wait_before_us != '0) |->
			(out_q.nibble == lcdns_pkg::WAKE_NIBBLE && !out_q.register_select))
		else $error("power-up wait on a nibble other than the first wake-up");

	a_pop_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_valid_q && !at_end) |-> !q_pop)
		else $error("new request loaded before current one finished");

endmodule

FILE: rtl/core/char_lcd_nibble_sequencer.sv
// Character LCD nibble sequencer (4-bit controller interface). Each input
// transaction is a request: show a character, set the cursor, or run the
// power-up initialization; it becomes a run of nibble-write transactions
// on the output, each carrying register select, the nibble, the waits
// before and after it, and a last flag on the final nibble of the request.
// A front stage classifies requests into descriptors (form feed, newline
// and backspace become commands; cursor requests get their DDRAM address)
// and writes them into a small queue; a back stage reads the queue and
// issues one nibble per cycle, when out_ready allows, through an output
// register that sets the sustained rate. Characters and cursor requests
// become two nibble writes, initialization twelve; opcode 3 is accepted
// and produces nothing. The input stays open while the queue has room, so
// a stalled output does not block acceptance until the FIFO_DEPTH entries
// are full. Configuration (display type, line length) must be written only
// while the block is idle.
module char_lcd_nibble_sequencer #(
	parameter int FIFO_DEPTH = lcdns_pkg::FIFO_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration write port
	input  logic              cfg_we,
	input  logic              cfg_addr,
	input  logic [6:0]        cfg_wdata,
	// request channel
	input  logic              in_valid,
	output logic              in_ready,
	input  lcdns_pkg::in_t    in_data,
	// nibble write channel
	output logic              out_valid,
	input  logic              out_ready,
	output lcdns_pkg::out_t   out_data
);

	logic             take;
	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_empty;
	lcdns_pkg::desc_t f_desc;
	lcdns_pkg::desc_t q_desc;

	// accept whenever the queue can take a descriptor
	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;

	lcdns_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.take      (take),
		.req       (in_data),
		.push      (push),
		.desc      (f_desc)
	);

	lcdns_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (f_desc),
		.pop    (pop),
		.rdata  (q_desc),
		.full   (q_full),
		.empty  (q_empty)
	);

	// back stage: steps through nibbles of the descriptor popped from the queue head
	lcdns_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (!q_empty),
		.q_desc    (q_desc),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: tb/lcd_nibble_checker.sv
`timescale 1ns / 100ps

module lcd_nibble_checker
	import lcdns_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_addr,
	input  logic [6:0] cfg_wdata,
	input  logic       in_valid,
	input  logic       in_ready,
	input  in_t        in_data,
	input  logic       out_valid,
	input  logic       out_ready,
	input  out_t       out_data,
	output int         pending,
	output int         fail_count
);

	localparam logic RS_COMMAND = 1'b0;
	localparam logic RS_DATA    = 1'b1;
	localparam int   PRINT_CAP  = 100;

	// shadow of the block's registers
	logic [1:0] display_type_q;
	logic [6:0] line_length_q;

	// nibble writes owed by the block, oldest first
	out_t nibble_writes_q[$];

	task automatic report_mismatch(input string what);
		if (fail_count < PRINT_CAP)
			$display("%0t ns  %s", $time, what);
		fail_count++;
	endtask

	function automatic void push_write(input logic rs, input logic [3:0] nib,
			input logic [14:0] before_us, input logic [12:0] after_us, input logic fin);
		out_t w;
		w.register_select = rs;
		w.nibble          = nib;
		w.wait_before_us  = before_us;
		w.wait_after_us   = after_us;
		w.last            = fin;
		nibble_writes_q.push_back(w);
	endfunction

	// high nibble first, only the low one carries the wait
	function automatic void push_byte(input logic rs, input logic [7:0] b,
			input logic [12:0] after_us, input logic fin);
		push_write(rs, b[7:4], '0, '0, 1'b0);
		push_write(rs, b[3:0], '0, after_us, fin);
	endfunction

	function automatic void expand_request(input in_t req);
		logic [7:0] base;
		logic [7:0] addr;
		case (opcode_t'(req.opcode))
			OP_CHAR: begin
				if (req.char_code == CH_FORM_FEED)
					push_byte(RS_COMMAND, CMD_CLEAR, CLEAR_WAIT_US, 1'b1);
				else if (req.char_code == CH_NEWLINE)
					push_byte(RS_COMMAND, CMD_ROW2_HOME, CMD_WAIT_US, 1'b1);
				else if (req.char_code == CH_BACKSPACE)
					push_byte(RS_COMMAND, CMD_SHIFT_LEFT, CMD_WAIT_US, 1'b1);
				else
					push_byte(RS_DATA, req.char_code, DATA_WAIT_US, 1'b1);
			end
			OP_CURSOR: begin
				case (req.row)
					3'd2: base = ROW2_BASE;
					3'd3: base = ROW1_BASE + {1'b0, line_length_q};
					3'd4: base = ROW2_BASE + {1'b0, line_length_q};
					default: base = ROW1_BASE;
				endcase
				addr = base + {1'b0, req.column} - 8'd1;
				push_byte(RS_COMMAND, CMD_SET_DDRAM | addr, CMD_WAIT_US, 1'b1);
			end
			OP_INIT: begin
				push_write(RS_COMMAND, WAKE_NIBBLE, POWERUP_WAIT_US, WAKE_WAIT_US, 1'b0);
				push_write(RS_COMMAND, WAKE_NIBBLE, '0, WAKE_WAIT_US, 1'b0);
				push_write(RS_COMMAND, WAKE_NIBBLE, '0, WAKE_WAIT_US, 1'b0);
				push_write(RS_COMMAND, FOUR_BIT_NIB, '0, '0, 1'b0);
				push_byte(RS_COMMAND, CMD_FUNC_SET | {4'b0000, display_type_q, 2'b00},
					CMD_WAIT_US, 1'b0);
				push_byte(RS_COMMAND, CMD_DISP_ON, CMD_WAIT_US, 1'b0);
				push_byte(RS_COMMAND, CMD_CLEAR, CMD_WAIT_US, 1'b0);
				push_byte(RS_COMMAND, CMD_ENTRY_MODE, CMD_WAIT_US, 1'b1);
			end
			default: ;
		endcase
	endfunction

	task automatic check_write(input out_t got);
		out_t want;
		if (nibble_writes_q.size() == 0) begin
			report_mismatch($sformatf("nibble write with nothing owed: %h", got));
			return;
		end
		want = nibble_writes_q.pop_front();
		if (got.register_select !== want.register_select)
			report_mismatch($sformatf("register_select %b, want %b",
				got.register_select, want.register_select));
		if (got.nibble !== want.nibble)
			report_mismatch($sformatf("nibble %h, want %h", got.nibble, want.nibble));
		if (got.wait_before_us !== want.wait_before_us)
			report_mismatch($sformatf("wait_before_us %0d, want %0d",
				got.wait_before_us, want.wait_before_us));
		if (got.wait_after_us !== want.wait_after_us)
			report_mismatch($sformatf("wait_after_us %0d, want %0d",
				got.wait_after_us, want.wait_after_us));
		if (got.last !== want.last)
			report_mismatch($sformatf("last %b, want %b", got.last, want.last));
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			display_type_q = DISPLAY_TYPE_RST;
			line_length_q  = LINE_LENGTH_RST;
			nibble_writes_q.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_addr == CFG_DISPLAY_TYPE)
					display_type_q = cfg_wdata[1:0];
				else
					line_length_q = cfg_wdata;
			end
			if (in_valid && in_ready)
				expand_request(in_data);
			if (out_valid && out_ready)
				check_write(out_data);
			pending = nibble_writes_q.size();
		end
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import lcdns_pkg::*;

	// idle gap after the last owed write before a register write: covers a
	// full init run still draining through the queue and output register
	localparam int SETTLE_CYCLES   = 32;
	// cycles with no transaction on either channel before giving up
	localparam int STALL_LIMIT     = 3000;
	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 40;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_addr;
	logic [6:0] cfg_wdata;
	logic       in_valid;
	logic       in_ready;
	in_t        in_data;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_t       out_data;

	int pending;
	int fail_count;

	// idling controls, switched per phase by the stimulus
	bit sender_gaps;
	bit receiver_stalls;
	int stall_left = 0;

	char_lcd_nibble_sequencer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	lcd_nibble_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.pending    (pending),
		.fail_count (fail_count)
	);

	// 12 ns period
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Receiver side: out_ready changes on the falling edge only. Stalls come
	// in random bursts while receiver_stalls is set.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 18) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic in_t request(input opcode_t op, input logic [7:0] ch,
			input logic [6:0] col, input logic [2:0] row);
		in_t r;
		r.opcode    = op;
		r.char_code = ch;
		r.column    = col;
		r.row       = row;
		return r;
	endfunction

	// Random request: mostly characters and cursor moves, a few inits and
	// unused opcodes; fields the opcode ignores keep random content.
	function automatic in_t random_request();
		logic [31:0] bits;
		in_t         r;
		int          pick;
		bits = $urandom;
		r    = bits[$bits(in_t)-1:0];
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			r.opcode = OP_CHAR;
			if ($urandom_range(0, 4) == 0) begin
				case ($urandom_range(0, 2))
					0: r.char_code = CH_FORM_FEED;
					1: r.char_code = CH_NEWLINE;
					default: r.char_code = CH_BACKSPACE;
				endcase
			end
		end else if (pick < 85) begin
			r.opcode = OP_CURSOR;
			// mostly legal positions; the rest keeps random rows and columns
			if ($urandom_range(0, 3) != 0) begin
				r.row    = 3'($urandom_range(1, 4));
				r.column = 7'($urandom_range(1, 64));
			end
		end else if (pick < 94) begin
			r.opcode = OP_INIT;
		end else if (pick < 97) begin
			r.opcode = OP_NONE;
		end
		return r;
	endfunction

	// One request transaction. Optional gap first, then valid held with the
	// payload steady until the rising edge that sees ready.
	task automatic send_request(input in_t req);
		int          gap;
		logic [31:0] junk;
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			gap  = $urandom_range(1, 18);
			junk = $urandom;
			@(negedge clk);
			in_valid <= 1'b0;
			in_data  <= junk[$bits(in_t)-1:0];
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= req;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Registers only change with the block idle: drop valid, let every owed
	// write arrive, give an opcode-3 or late init time to drain, then write.
	task automatic configure(input logic [1:0] disp, input logic [6:0] len);
		logic [4:0] upper;
		upper = 5'($urandom_range(0, 31));
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= CFG_DISPLAY_TYPE;
		cfg_wdata <= {upper, disp};  // upper bits are don't-care for the 2-bit register
		@(negedge clk);
		cfg_addr  <= CFG_LINE_LENGTH;
		cfg_wdata <= len;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// A quiet stretch on both channels that reaches STALL_LIMIT means a hang.
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("char_lcd_nibble_sequencer: mismatch");
		$finish;
	end

	initial begin : stimulus
		in_t        directed_reqs[$];
		int         phase;
		logic [1:0] disp_pick;
		logic [6:0] len_pick;

		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_addr        = CFG_DISPLAY_TYPE;
		cfg_wdata       = '0;
		in_valid        = 1'b0;
		in_data         = '0;
		sender_gaps     = 1'b1;
		receiver_stalls = 1'b1;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part, reset register values (display type 2, 20 per line).
		// Init first, then character extremes and the three control characters.
		directed_reqs.push_back(request(OP_INIT,   8'h00, 7'd0,   3'd0));
		directed_reqs.push_back(request(OP_CHAR,   8'h00, 7'd0,   3'd0));
		directed_reqs.push_back(request(OP_CHAR,   8'hFF, 7'd127, 3'd7));
		directed_reqs.push_back(request(OP_CHAR,   CH_FORM_FEED, 7'd1, 3'd1));
		directed_reqs.push_back(request(OP_CHAR,   CH_NEWLINE,   7'd1, 3'd1));
		directed_reqs.push_back(request(OP_CHAR,   CH_BACKSPACE, 7'd1, 3'd1));
		directed_reqs.push_back(request(OP_CHAR,   8'h48, 7'd5,   3'd2));
		// cursor: each row, column bounds, rows outside 1..4, column zero wrap
		directed_reqs.push_back(request(OP_CURSOR, 8'h00, 7'd1,   3'd1));
		directed_reqs.push_back(request(OP_CURSOR, 8'hFF, 7'd64,  3'd2));
		directed_reqs.push_back(request(OP_CURSOR, 8'h00, 7'd1,   3'd3));
		directed_reqs.push_back(request(OP_CURSOR, 8'h00, 7'd64,  3'd4));
		directed_reqs.push_back(request(OP_CURSOR, 8'h00, 7'd5,   3'd0));
		directed_reqs.push_back(request(OP_CURSOR, 8'h00, 7'd127, 3'd7));
		directed_reqs.push_back(request(OP_CURSOR, 8'h00, 7'd0,   3'd5));
		directed_reqs.push_back(request(OP_CURSOR, 8'h00, 7'd1,   3'd6));
		directed_reqs.push_back(request(OP_CURSOR, 8'h00, 7'd127, 3'd4));
		directed_reqs.push_back(request(OP_CURSOR, 8'h00, 7'd0,   3'd1));
		// unused opcode yields nothing; the next request must still line up
		directed_reqs.push_back(request(OP_NONE,   8'hFF, 7'd127, 3'd7));
		directed_reqs.push_back(request(OP_CHAR,   8'h7F, 7'd127, 3'd7));
		directed_reqs.push_back(request(OP_NONE,   8'h00, 7'd0,   3'd0));
		directed_reqs.push_back(request(OP_INIT,   8'hFF, 7'd127, 3'd7));
		foreach (directed_reqs[i])
			send_request(directed_reqs[i]);

		// Random phases, each under new register values: extremes first,
		// then random ones. The last phase runs with no idling on either side.
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin disp_pick = 2'd0; len_pick = 7'd1;   end
				1: begin disp_pick = 2'd3; len_pick = 7'd64;  end
				2: begin disp_pick = 2'd1; len_pick = 7'd127; end
				3: begin disp_pick = 2'd2; len_pick = 7'd0;   end
				default: begin
					disp_pick = 2'($urandom_range(0, 3));
					len_pick  = 7'($urandom_range(1, 64));
				end
			endcase
			configure(disp_pick, len_pick);
			if (phase == PHASES - 1) begin
				sender_gaps     = 1'b0;
				receiver_stalls = 1'b0;
			end else if (phase == 0) begin
				sender_gaps     = 1'b1;
				receiver_stalls = 1'b1;
			end else begin
				sender_gaps     = 1'($urandom_range(0, 1));
				receiver_stalls = 1'($urandom_range(0, 1));
			end
			// init right away so the function set reflects the new display type
			send_request(request(OP_INIT, 8'h00, 7'd0, 3'd0));
			repeat (ITEMS_PER_PHASE) send_request(random_request());
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		// extra cycles catch any stray write after the last owed one
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (fail_count == 0)
			$display("char_lcd_nibble_sequencer: match");
		else
			$display("char_lcd_nibble_sequencer: mismatch");
		$finish;
	end

endmodule
